### src/tmd_primitive_packet_parser_defines.svh
// Assertion macros for the primitive packet parser checker.
`ifndef TMD_PRIMITIVE_PACKET_PARSER_DEFINES_SVH
`define TMD_PRIMITIVE_PACKET_PARSER_DEFINES_SVH

// Property sampled on clk, switched off while rst is high.
`define TMD_PP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on clk, also checked through reset.
`define TMD_PP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tmd_pp_pkg.sv
package tmd_pp_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] MODE_QUAD_BIT    = 8'h08;
  localparam logic [7:0] MODE_TEX_BIT     = 8'h04;
  localparam logic [7:0] FLAG_NOLIGHT_BIT = 8'h04;
  localparam logic [2:0] MODE_POLYGON     = 3'b001;

  localparam logic [4:0] POS_OLEN    = 5'd0;
  localparam logic [4:0] POS_ILEN    = 5'd1;
  localparam logic [4:0] POS_FLAG    = 5'd2;
  localparam logic [4:0] POS_MODE    = 5'd3;
  localparam logic [4:0] POS_RED     = 5'd4;
  localparam logic [4:0] POS_GREEN   = 5'd5;
  localparam logic [4:0] POS_BLUE    = 5'd6;
  localparam logic [4:0] POS_CODE    = 5'd7;
  localparam logic [4:0] POS_CORNERS = 5'd8;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LAYOUT = 2'd1,
    ERR_LENGTH = 2'd2,
    ERR_RANGE  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    REG_VERTEX_COUNT    = 2'd0,
    REG_NORMAL_COUNT    = 2'd1,
    REG_PRIMITIVE_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        is_error;
    err_t        error_code;
    logic [1:0]  corner_number;
    logic [15:0] vertex_number;
    logic [15:0] normal_number;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_quad;
    logic        last_corner;
    logic        last_primitive;
  } res_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } q_ctrl_t;

endpackage

### src/tmd_pp_front.sv
module tmd_pp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                block_start,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  output logic                push,
  output tmd_pp_pkg::res_t    res
);

  logic [16:0] vertex_count;
  logic [16:0] normal_count;
  logic [15:0] primitive_count;

  logic [4:0]  byte_position, byte_position_next;
  logic [7:0]  length_words, length_words_next;
  logic [7:0]  flag_byte, flag_byte_next;
  logic        quad_mode, quad_mode_next;
  logic [23:0] colour_word, colour_word_next;
  logic [23:0] partial_index, partial_index_next;
  logic [15:0] primitives_done, primitives_done_next;
  logic        halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= '0;
      normal_count    <= '0;
      primitive_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tmd_pp_pkg::REG_VERTEX_COUNT:    vertex_count    <= cfg_data;
        tmd_pp_pkg::REG_NORMAL_COUNT:    normal_count    <= cfg_data;
        tmd_pp_pkg::REG_PRIMITIVE_COUNT: primitive_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [4:0]  pos;
    logic [15:0] done;
    logic        halt;
    logic [4:0]  off;
    logic [15:0] done_inc;
    logic [15:0] vertex;
    logic [15:0] normal;
    logic [7:0]  ilen_want;

    byte_position_next   = byte_position;
    length_words_next    = length_words;
    flag_byte_next       = flag_byte;
    quad_mode_next       = quad_mode;
    colour_word_next     = colour_word;
    partial_index_next   = partial_index;
    primitives_done_next = primitives_done;
    halted_next          = halted;
    push                 = 1'b0;
    res                  = '0;

    pos       = block_start ? '0 : byte_position;
    done      = block_start ? '0 : primitives_done;
    halt      = block_start ? 1'b0 : halted;
    off       = pos - tmd_pp_pkg::POS_CORNERS;
    done_inc  = done + 16'd1;
    normal    = partial_index[15:0];
    vertex    = {data_byte, partial_index[23:16]};
    ilen_want = ((data_byte & tmd_pp_pkg::MODE_QUAD_BIT) != 8'd0) ? 8'd5 : 8'd4;

    if (accept) begin
      if (block_start) begin
        byte_position_next   = '0;
        primitives_done_next = '0;
        partial_index_next   = '0;
        halted_next          = 1'b0;
      end
      if (!halt && done < primitive_count) begin
        byte_position_next = pos + 5'd1;
        if (pos == tmd_pp_pkg::POS_ILEN) begin
          length_words_next = data_byte;
        end else if (pos == tmd_pp_pkg::POS_FLAG) begin
          flag_byte_next = data_byte;
        end else if (pos == tmd_pp_pkg::POS_MODE) begin
          quad_mode_next = (data_byte & tmd_pp_pkg::MODE_QUAD_BIT) != 8'd0;
          if (data_byte[7:5] != tmd_pp_pkg::MODE_POLYGON
              || (data_byte & tmd_pp_pkg::MODE_TEX_BIT) != 8'd0
              || (flag_byte & tmd_pp_pkg::FLAG_NOLIGHT_BIT) != 8'd0) begin
            push           = 1'b1;
            res.is_error   = 1'b1;
            res.error_code = tmd_pp_pkg::ERR_LAYOUT;
            halted_next    = 1'b1;
          end else if (length_words != ilen_want) begin
            push           = 1'b1;
            res.is_error   = 1'b1;
            res.error_code = tmd_pp_pkg::ERR_LENGTH;
            halted_next    = 1'b1;
          end
        end else if (pos == tmd_pp_pkg::POS_RED) begin
          colour_word_next[7:0] = data_byte;
        end else if (pos == tmd_pp_pkg::POS_GREEN) begin
          colour_word_next[15:8] = data_byte;
        end else if (pos == tmd_pp_pkg::POS_BLUE) begin
          colour_word_next[23:16] = data_byte;
        end else if (pos >= tmd_pp_pkg::POS_CORNERS) begin
          case (off[1:0])
            2'd0: partial_index_next = {16'd0, data_byte};
            2'd1: partial_index_next[15:8] = data_byte;
            2'd2: partial_index_next[23:16] = data_byte;
            default: begin
              push = 1'b1;
              if ({1'b0, vertex} >= vertex_count || {1'b0, normal} >= normal_count) begin
                res.is_error   = 1'b1;
                res.error_code = tmd_pp_pkg::ERR_RANGE;
                halted_next    = 1'b1;
              end else begin
                res.corner_number = off[3:2];
                res.vertex_number = vertex;
                res.normal_number = normal;
                res.red           = colour_word[7:0];
                res.green         = colour_word[15:8];
                res.blue          = colour_word[23:16];
                res.is_quad       = quad_mode;
                if (off[3:2] >= (quad_mode ? 2'd3 : 2'd2)) begin
                  res.last_corner      = 1'b1;
                  res.last_primitive   = done_inc >= primitive_count;
                  primitives_done_next = done_inc;
                  byte_position_next   = '0;
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      length_words    <= '0;
      flag_byte       <= '0;
      quad_mode       <= 1'b0;
      colour_word     <= '0;
      partial_index   <= '0;
      primitives_done <= '0;
      halted          <= 1'b1;
    end else begin
      byte_position   <= byte_position_next;
      length_words    <= length_words_next;
      flag_byte       <= flag_byte_next;
      quad_mode       <= quad_mode_next;
      colour_word     <= colour_word_next;
      partial_index   <= partial_index_next;
      primitives_done <= primitives_done_next;
      halted          <= halted_next;
    end
  end

endmodule

### src/tmd_pp_fifo.sv
module tmd_pp_fifo #(
  parameter int DEPTH = tmd_pp_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tmd_pp_pkg::res_t    wr_data,
  output logic                full,
  input  tmd_pp_pkg::q_ctrl_t ctrl_in,
  output tmd_pp_pkg::q_ctrl_t ctrl_out,
  output tmd_pp_pkg::res_t    rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tmd_pp_pkg::res_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full           = count == CNT_W'(DEPTH);
  assign ctrl_out.empty = count == '0;
  assign ctrl_out.pop   = do_pop;
  assign do_pop         = ctrl_in.pop && (count != '0);
  assign rd_data        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/tmd_pp_back.sv
module tmd_pp_back (
  input  logic                clk,
  input  logic                rst,
  input  tmd_pp_pkg::q_ctrl_t q_status,
  output tmd_pp_pkg::q_ctrl_t q_req,
  input  tmd_pp_pkg::res_t    q_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);

  tmd_pp_pkg::res_t out_res;
  logic             load;

  assign load        = !q_status.empty && (!m_tvalid || m_tready);
  assign q_req.pop   = load;
  assign q_req.empty = q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= q_data;
    end
  end

  assign m_tdata = {4'd0, out_res.last_corner, out_res.is_quad, out_res.blue,
                    out_res.green, out_res.red, out_res.normal_number,
                    out_res.vertex_number, out_res.corner_number};
  assign m_tuser = {out_res.error_code, out_res.is_error};
  assign m_tlast = out_res.last_primitive;

endmodule

### src/tmd_primitive_packet_parser.sv
// A result is written into the result queue, then loaded into the output register behind m_tvalid.
// Throughput: one byte per cycle sustained; the combinational parse step and one queue pop
// per cycle set it, and s_tready drops only while the result queue is full.
// Reset (rst, synchronous, active high): config registers read zero, queue and output empty, and
// the parser stays halted until a byte with block_start set.
module tmd_primitive_packet_parser #(
  parameter int FIFO_DEPTH = tmd_pp_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] block_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [1:0] corner_number, [17:2] vertex_number,
                                 // [33:18] normal_number, [41:34] red, [49:42] green,
                                 // [57:50] blue, [58] is_quad, [59] last_corner
  output logic [2:0]  m_tuser,   // [0] is_error, [2:1] error_code
  output logic        m_tlast,   // last_primitive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic                accept;
  logic                push;
  logic                full;
  tmd_pp_pkg::res_t    push_res;
  tmd_pp_pkg::res_t    head_res;
  tmd_pp_pkg::q_ctrl_t q_status;
  tmd_pp_pkg::q_ctrl_t q_req;

  assign s_tready  = !full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  tmd_pp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .block_start (s_tuser[0]),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .res         (push_res)
  );

  tmd_pp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_res),
    .full     (full),
    .ctrl_in  (q_req),
    .ctrl_out (q_status),
    .rd_data  (head_res)
  );

  tmd_pp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_req    (q_req),
    .q_data   (head_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### src/tmd_pp_checker.sv
`include "tmd_primitive_packet_parser_defines.svh"

module tmd_pp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  `TMD_PP_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")
  `TMD_PP_ASSERT(a_hold,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast)),
    "stalled transaction changed")
  `TMD_PP_ASSERT(a_err_clean,
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0 && !m_tlast),
    "error transaction carries corner data")
  `TMD_PP_ASSERT(a_err_code,
    m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] != 2'd0)),
    "error flag and code disagree")

endmodule

bind tmd_primitive_packet_parser tmd_pp_checker u_checker (.*);
